/* rtl/core/dpic_pkg.sv */
`timescale 1ns / 1ps

package dpic_pkg;

  // Item layouts
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [11:0] temperature_tenths;
    logic [9:0]         humidity_tenths;
    logic [6:0]         soil_one_percent;
    logic [6:0]         soil_two_percent;
    logic [6:0]         water_percent;
    logic               pump_select;
    logic               switch_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] event_bits;
    logic        pump_one_on;
    logic        pump_two_on;
  } out_item_t;

  // Operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_MANUAL = 2'd2;
  localparam logic [1:0] OP_AUTO   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SEC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MED_SEC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SEC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAN_SEC   = 3'd5;

  // Configuration reset values
  localparam logic [6:0]  SOIL_THR_RST  = 7'd25;
  localparam logic [6:0]  WATER_THR_RST = 7'd10;
  localparam logic [11:0] SHORT_SEC_RST = 12'd10;
  localparam logic [11:0] MED_SEC_RST   = 12'd20;
  localparam logic [11:0] LONG_SEC_RST  = 12'd30;
  localparam logic [11:0] MAN_SEC_RST   = 12'd10;
  localparam logic [11:0] AUTO_SEC_RST  = 12'd10;

  // Decision thresholds: temperature and humidity in tenths, hysteresis in percent
  localparam logic signed [11:0] TEMP_HOT     = 12'sd320;
  localparam logic signed [11:0] TEMP_WARM    = 12'sd250;
  localparam logic signed [11:0] TEMP_RECOVER = 12'sd300;
  localparam logic [9:0] HUM_DRY    = 10'd100;
  localparam logic [9:0] HUM_NORMAL = 10'd180;
  localparam logic [9:0] HUM_LOW    = 10'd50;
  localparam logic [9:0] HUM_HIGH   = 10'd250;
  localparam logic [7:0] SOIL_HYST  = 8'd10;
  localparam logic [7:0] WATER_HYST = 8'd5;
  localparam logic [11:0] ELAPSED_MAX = 12'hFFF;

  // Event bit positions
  localparam int unsigned EV_SOIL_LSB     = 0;
  localparam int unsigned EV_TEMP         = 2;
  localparam int unsigned EV_HUM_LOW      = 3;
  localparam int unsigned EV_HUM_HIGH     = 4;
  localparam int unsigned EV_WATER        = 5;
  localparam int unsigned EV_AUTO_LSB     = 6;
  localparam int unsigned EV_MAN_ON_LSB   = 8;
  localparam int unsigned EV_MAN_OFF_LSB  = 10;
  localparam int unsigned EV_AUTO_END_LSB = 12;
  localparam int unsigned EV_MAN_END_LSB  = 14;

  // Latched alert positions
  localparam int unsigned ALR_SOIL_LSB = 0;
  localparam int unsigned ALR_TEMP     = 2;
  localparam int unsigned ALR_HUM      = 3;
  localparam int unsigned ALR_WATER    = 4;

endpackage

/* rtl/core/dual_pump_irrigation_controller.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_item  (in_item_t)
// out_      output     out_valid / out_stall  out_item (out_item_t)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; its result is presented
// after it passes the input register and then the result register.
// The controller state is updated in the same cycle as the result register
// is loaded, so items are processed strictly in order.
// rst_n is synchronous and active low; it restores all registers and state but the payload registers.
// A stalled output holds its item; the input register still takes one more
// item, and in_stall rises only when both registers are full and out_stall
// is high.

module dual_pump_irrigation_controller
  import dpic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]          cfg_data
);

  // Humidity classes for the rule table
  localparam logic [1:0] AIR_DRY    = 2'd0;
  localparam logic [1:0] AIR_NORMAL = 2'd1;
  localparam logic [1:0] AIR_HUMID  = 2'd2;

  // Configuration registers
  logic [6:0]  soil_thr_r, water_thr_r;
  logic [11:0] short_sec_r, med_sec_r, long_sec_r, man_sec_r;

  // Controller state
  logic [1:0]  running_r, running_nxt;
  logic [1:0]  is_auto_r, is_auto_nxt;
  logic [11:0] elapsed_r [2];
  logic [11:0] elapsed_nxt [2];
  logic [11:0] auto_sec_r [2];
  logic [11:0] auto_sec_nxt [2];
  logic        auto_en_r, auto_en_nxt;
  logic [4:0]  alert_r, alert_nxt;

  // Pipeline registers
  in_item_t    s1_item_r;
  logic        s1_valid_r;
  out_item_t   out_item_r;
  logic        out_valid_r;

  logic        in_take;
  logic        s1_adv;

  // Working signals for the item in the input register
  logic [6:0]  soil_pct [2];
  logic [1:0]  soil_dry;
  logic [1:0]  soil_wet;
  logic [7:0]  soil_clr_lim;
  logic [7:0]  water_clr_lim;
  logic        water_ok;
  logic        hum_out;
  logic [1:0]  air_cls;
  logic [11:0] rule_sec;
  logic [11:0] tick_elapsed [2];
  logic [11:0] tick_limit [2];
  logic [1:0]  sel_mask;
  logic [15:0] ev;

  // Handshake. The result register frees when it is empty or being taken.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soil_thr_r  <= SOIL_THR_RST;
      water_thr_r <= WATER_THR_RST;
      short_sec_r <= SHORT_SEC_RST;
      med_sec_r   <= MED_SEC_RST;
      long_sec_r  <= LONG_SEC_RST;
      man_sec_r   <= MAN_SEC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOIL_THR:  soil_thr_r  <= cfg_data[6:0];
        CFG_WATER_THR: water_thr_r <= cfg_data[6:0];
        CFG_SHORT_SEC: short_sec_r <= cfg_data;
        CFG_MED_SEC:   med_sec_r   <= cfg_data;
        CFG_LONG_SEC:  long_sec_r  <= cfg_data;
        CFG_MAN_SEC:   man_sec_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Thresholds and classification of the sample
  assign soil_pct[0]   = s1_item_r.soil_one_percent;
  assign soil_pct[1]   = s1_item_r.soil_two_percent;
  assign soil_clr_lim  = {1'b0, soil_thr_r} + SOIL_HYST;
  assign water_clr_lim = {1'b0, water_thr_r} + WATER_HYST;
  assign water_ok      = s1_item_r.water_percent > water_thr_r;
  assign hum_out       = (s1_item_r.humidity_tenths < HUM_LOW) ||
                         (s1_item_r.humidity_tenths > HUM_HIGH);
  assign sel_mask      = {s1_item_r.pump_select, !s1_item_r.pump_select};

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      soil_dry[p] = soil_pct[p] <= soil_thr_r;
      soil_wet[p] = {1'b0, soil_pct[p]} > soil_clr_lim;
    end
  end

  // Run time table: temperature band by humidity class.
  always_comb begin
    if (s1_item_r.humidity_tenths < HUM_DRY) begin
      air_cls = AIR_DRY;
    end else if (s1_item_r.humidity_tenths < HUM_NORMAL) begin
      air_cls = AIR_NORMAL;
    end else begin
      air_cls = AIR_HUMID;
    end
    if (s1_item_r.temperature_tenths >= TEMP_HOT) begin
      rule_sec = (air_cls == AIR_HUMID) ? med_sec_r : long_sec_r;
    end else if (s1_item_r.temperature_tenths >= TEMP_WARM) begin
      rule_sec = (air_cls == AIR_HUMID) ? short_sec_r : med_sec_r;
    end else begin
      rule_sec = (air_cls == AIR_DRY) ? med_sec_r : short_sec_r;
    end
  end

  // Timer step for each pump: saturating count and its stop limit.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      tick_elapsed[p] = (elapsed_r[p] < ELAPSED_MAX) ? elapsed_r[p] + 12'd1 : elapsed_r[p];
      tick_limit[p]   = is_auto_r[p] ? auto_sec_r[p] : man_sec_r;
    end
  end

  always_comb begin
    running_nxt  = running_r;
    is_auto_nxt  = is_auto_r;
    elapsed_nxt  = elapsed_r;
    auto_sec_nxt = auto_sec_r;
    auto_en_nxt  = auto_en_r;
    alert_nxt    = alert_r;
    ev           = '0;
    case (s1_item_r.operation)
      OP_SAMPLE: begin
        // Each alert is reported only on the sample that latches it, and clears once the
        // reading is back past its hysteresis limit (humidity: once back in range).
        for (int p = 0; p < 2; p++) begin
          if (!alert_r[ALR_SOIL_LSB + p]) begin
            if (soil_dry[p]) begin
              alert_nxt[ALR_SOIL_LSB + p] = 1'b1;
              ev[EV_SOIL_LSB + p]         = 1'b1;
            end
          end else if (soil_wet[p]) begin
            alert_nxt[ALR_SOIL_LSB + p] = 1'b0;
          end
        end
        if (!alert_r[ALR_TEMP]) begin
          if (s1_item_r.temperature_tenths >= TEMP_HOT) begin
            alert_nxt[ALR_TEMP] = 1'b1;
            ev[EV_TEMP]         = 1'b1;
          end
        end else if (s1_item_r.temperature_tenths < TEMP_RECOVER) begin
          alert_nxt[ALR_TEMP] = 1'b0;
        end
        if (!alert_r[ALR_HUM]) begin
          if (hum_out) begin
            alert_nxt[ALR_HUM] = 1'b1;
            if (s1_item_r.humidity_tenths < HUM_LOW) begin
              ev[EV_HUM_LOW] = 1'b1;
            end else begin
              ev[EV_HUM_HIGH] = 1'b1;
            end
          end
        end else if (!hum_out) begin
          alert_nxt[ALR_HUM] = 1'b0;
        end
        if (!alert_r[ALR_WATER]) begin
          if (!water_ok) begin
            alert_nxt[ALR_WATER] = 1'b1;
            ev[EV_WATER]         = 1'b1;
          end
        end else if ({1'b0, s1_item_r.water_percent} > water_clr_lim) begin
          alert_nxt[ALR_WATER] = 1'b0;
        end
        // Automatic start, in auto mode, of an idle pump whose bed is dry while water is sufficient.
        for (int p = 0; p < 2; p++) begin
          if (auto_en_r && !running_r[p] && soil_dry[p] && water_ok) begin
            auto_sec_nxt[p]     = rule_sec;
            running_nxt[p]      = 1'b1;
            is_auto_nxt[p]      = 1'b1;
            elapsed_nxt[p]      = '0;
            ev[EV_AUTO_LSB + p] = 1'b1;
          end
        end
      end
      OP_TICK: begin
        for (int p = 0; p < 2; p++) begin
          if (running_r[p]) begin
            elapsed_nxt[p] = tick_elapsed[p];
            if (tick_elapsed[p] >= tick_limit[p]) begin
              running_nxt[p] = 1'b0;
              if (is_auto_r[p]) begin
                ev[EV_AUTO_END_LSB + p] = 1'b1;
              end else begin
                ev[EV_MAN_END_LSB + p] = 1'b1;
              end
            end
          end
        end
      end
      OP_MANUAL: begin
        // Manual commands have no effect while auto mode is on.
        if (!auto_en_r) begin
          is_auto_nxt = is_auto_r & ~sel_mask;
          if (s1_item_r.switch_value) begin
            running_nxt                         = running_r | sel_mask;
            elapsed_nxt[s1_item_r.pump_select]  = '0;
            ev[EV_MAN_ON_LSB +: 2]              = sel_mask;
          end else begin
            running_nxt             = running_r & ~sel_mask;
            ev[EV_MAN_OFF_LSB +: 2] = running_r & sel_mask;
          end
        end
      end
      OP_AUTO: begin
        // Leaving auto mode stops both pumps without reporting it.
        auto_en_nxt = s1_item_r.switch_value;
        if (!s1_item_r.switch_value) begin
          running_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      running_r   <= '0;
      is_auto_r   <= '0;
      elapsed_r   <= '{default: '0};
      auto_sec_r  <= '{default: AUTO_SEC_RST};
      auto_en_r   <= 1'b0;
      alert_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        running_r   <= running_nxt;
        is_auto_r   <= is_auto_nxt;
        elapsed_r   <= elapsed_nxt;
        auto_sec_r  <= auto_sec_nxt;
        auto_en_r   <= auto_en_nxt;
        alert_r     <= alert_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r.event_bits  <= ev;
      out_item_r.pump_one_on <= running_nxt[0];
      out_item_r.pump_two_on <= running_nxt[1];
    end
  end

endmodule

/* rtl/core/dpic_checker.sv */
`timescale 1ns / 1ps

module dpic_checker
  import dpic_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_item
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Pump one reported as started is running in the same item.
  a_start_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_bits[EV_AUTO_LSB] || out_item.event_bits[EV_MAN_ON_LSB])
    |-> out_item.pump_one_on)
    else $error("pump one start reported but pump off");

  // Pump two reported as stopped is off in the same item.
  a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_bits[EV_MAN_OFF_LSB + 1] ||
                  out_item.event_bits[EV_AUTO_END_LSB + 1] ||
                  out_item.event_bits[EV_MAN_END_LSB + 1])
    |-> !out_item.pump_two_on)
    else $error("pump two stop reported but pump on");

  // Sample events and command or timer events never share an item.
  a_ev_groups: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_bits[7:0] != 8'd0) |-> out_item.event_bits[15:8] == 8'd0)
    else $error("sample and command events mixed");

  // Humidity alert reports one direction only.
  a_hum_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.event_bits[EV_HUM_LOW] && out_item.event_bits[EV_HUM_HIGH]))
    else $error("humidity alert in both directions");

endmodule

bind dual_pump_irrigation_controller dpic_checker u_dpic_checker (.*);
